// ----- rtl/dwarf_line_program_lookup_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the line program lookup unit
// Each macro expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef DWARF_LINE_PROGRAM_LOOKUP_UNIT_MACROS_SVH
`define DWARF_LINE_PROGRAM_LOOKUP_UNIT_MACROS_SVH

// same-cycle implication
`define DLPL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DLPL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/dlpl_pkg.sv -----
// ----------------------------------------------------------------------------
// dlpl_pkg
// Shared types and constants of the line program lookup unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package dlpl_pkg;

  // standard opcodes
  localparam logic [7:0] OP_EXTENDED      = 8'd0;
  localparam logic [7:0] OP_COPY          = 8'd1;
  localparam logic [7:0] OP_ADVANCE_PC    = 8'd2;
  localparam logic [7:0] OP_ADVANCE_LINE  = 8'd3;
  localparam logic [7:0] OP_SET_FILE      = 8'd4;
  localparam logic [7:0] OP_SET_COLUMN    = 8'd5;
  localparam logic [7:0] OP_NEGATE_STMT   = 8'd6;
  localparam logic [7:0] OP_BASIC_BLOCK   = 8'd7;
  localparam logic [7:0] OP_CONST_ADD_PC  = 8'd8;
  localparam logic [7:0] OP_FIXED_ADV_PC  = 8'd9;
  localparam logic [7:0] OP_PROLOGUE_END  = 8'd10;
  localparam logic [7:0] OP_EPILOGUE_BEG  = 8'd11;

  // extended opcodes
  localparam logic [7:0] EXT_END_SEQUENCE = 8'd1;
  localparam logic [7:0] EXT_SET_ADDRESS  = 8'd2;
  localparam logic [7:0] EXT_SET_DISCRIM  = 8'd4;

  localparam logic [7:0] OPC_MAX = 8'd255;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INSN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_OPS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_STMT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_BASE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_RANGE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_OPCODE_BASE = 3'd6;

  // flag bits
  localparam int unsigned FL_STMT   = 0;
  localparam int unsigned FL_BBLOCK = 1;
  localparam int unsigned FL_PROLOG = 2;
  localparam int unsigned FL_EPILOG = 3;
  localparam int unsigned FL_INFUNC = 4;

  localparam int unsigned DIV_W = 64;

  typedef enum logic [2:0] {
    K_NONE, K_SIMPLE, K_ROW, K_SPECIAL, K_ADVPC, K_CONSTADD
  } kind_t;

  typedef enum logic [1:0] {
    DSEL_SPECIAL, DSEL_CONST, DSEL_ADV, DSEL_R9
  } dsel_t;

  typedef struct packed {
    logic  accept;
    logic  apply_simple;
    logic  div_start;
    dsel_t div_sel;
    logic  sp_line;
    logic  adv_from_opnd;
    logic  adv_from_quo;
    logic  q_from_adv;
    logic  ad1_capture;
    logic  ad2_capture;
    logic  mul;
    logic  add_addr;
    logic  row_update;
    logic  load_out;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  found;
    logic  div_busy;
    logic  m_is_one;
    logic  match;
    logic  out_full;
  } status_t;

endpackage
`default_nettype wire

// ----- rtl/dlpl_in_if.sv -----
// ----------------------------------------------------------------------------
// dlpl_in_if
// Instruction channel: one decoded line program instruction per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface dlpl_in_if;
  logic               valid;
  logic               ready;
  logic               unit_start;
  logic [7:0]         func;
  logic [7:0]         ext_func;
  logic [63:0]        operand;
  logic signed [31:0] line_delta;
  modport source (output valid, unit_start, func, ext_func, operand, line_delta,
                  input ready);
  modport sink   (input valid, unit_start, func, ext_func, operand, line_delta,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/dlpl_out_if.sv -----
// ----------------------------------------------------------------------------
// dlpl_out_if
// Result channel: one matched row per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface dlpl_out_if;
  logic               valid;
  logic               ready;
  logic [63:0]        range_begin;
  logic [63:0]        range_end;
  logic signed [31:0] line_number;
  logic [31:0]        column_number;
  logic [31:0]        file_index;
  logic [31:0]        discriminator_value;
  logic [4:0]         row_flags;
  modport source (output valid, range_begin, range_end, line_number, column_number,
                  file_index, discriminator_value, row_flags, input ready);
  modport sink   (input valid, range_begin, range_end, line_number, column_number,
                  file_index, discriminator_value, row_flags, output ready);
endinterface
`default_nettype wire

// ----- rtl/dlpl_cfg_if.sv -----
// ----------------------------------------------------------------------------
// dlpl_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface dlpl_cfg_if;
  import dlpl_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [63:0]          data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/dwarf_line_program_lookup_unit.sv -----
// ----------------------------------------------------------------------------
// dwarf_line_program_lookup_unit
// Runs the line-number state machine over decoded instructions and returns
// the first row whose address range covers the target address.
// ----------------------------------------------------------------------------
//  channel | dir | handshake        | payload
//  in_ch   | in  | valid/ready      | unit_start, func, ext_func, operand, line_delta
//  out_ch  | out | valid/ready      | range, line, column, file, discriminator, flags
//  cfg_ch  | in  | valid/ready(=1)  | index, data
//
//  One instruction at a time. Simple opcodes apply at decode; copy and
//  end_sequence go to the test step; special and const_add_pc divide by the
//  line range; with several operations per instruction, these and advance_pc
//  then divide by it on the bit-serial divider (64 steps, 16 on short ones).
//  Reset (rst_n low, synchronous) restores configuration, state and both rows.
//  A match waits in the test step while the previous result is still held.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dwarf_line_program_lookup_unit
  import dlpl_pkg::*;
#(
  parameter int unsigned ADDR_WIDTH = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  dlpl_in_if.sink   in_ch,
  dlpl_out_if.source out_ch,
  dlpl_cfg_if.sink  cfg_ch
);
  cmd_t    cmd;
  status_t st;
  logic    in_ready;

  // configuration writes are always taken; the source must send them only when idle, which the unit does not enforce
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;

  dlpl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  dlpl_dp #(.ADDR_WIDTH(ADDR_WIDTH)) u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_we                  (cfg_ch.valid),
    .cfg_idx                 (cfg_ch.index),
    .cfg_wdata               (cfg_ch.data),
    .in_unit_start           (in_ch.unit_start),
    .in_func                 (in_ch.func),
    .in_ext_func             (in_ch.ext_func),
    .in_operand              (in_ch.operand),
    .in_line_delta           (in_ch.line_delta),
    .cmd                     (cmd),
    .st                      (st),
    .out_valid               (out_ch.valid),
    .out_ready               (out_ch.ready),
    .out_range_begin         (out_ch.range_begin),
    .out_range_end           (out_ch.range_end),
    .out_line_number         (out_ch.line_number),
    .out_column_number       (out_ch.column_number),
    .out_file_index          (out_ch.file_index),
    .out_discriminator_value (out_ch.discriminator_value),
    .out_row_flags           (out_ch.row_flags)
  );
endmodule
`default_nettype wire

// ----- rtl/dlpl_div.sv -----
// ----------------------------------------------------------------------------
// dlpl_div
// Radix-2 restoring divider, 64-bit dividend by 8-bit divisor.
// Long mode runs 64 steps; short mode 16 steps for dividends below 2^16.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dlpl_div
  import dlpl_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic             long_mode,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [7:0]       divisor,
  output logic                  busy,
  output logic [DIV_W-1:0]      quotient,
  output logic [7:0]            remainder
);
  localparam int unsigned SHORT_W = 16;

  logic [6:0]       cnt_r;
  logic [DIV_W-1:0] quo_r;
  logic [7:0]       rem_r;
  logic [7:0]       dvs_r;
  logic [8:0]       trial;
  logic             ge;

  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= long_mode ? 7'(DIV_W) : 7'(SHORT_W);
      dvs_r <= divisor;
      rem_r <= '0;
      quo_r <= long_mode ? dividend : {dividend[SHORT_W-1:0], {(DIV_W-SHORT_W){1'b0}}};
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 7'd1;
      rem_r <= ge ? 8'(trial - {1'b0, dvs_r}) : trial[7:0];
      quo_r <= {quo_r[DIV_W-2:0], ge};
    end
  end

  assign busy      = cnt_r != '0;
  assign quotient  = quo_r;
  assign remainder = rem_r;
endmodule
`default_nettype wire

// ----- rtl/dlpl_dp.sv -----
// ----------------------------------------------------------------------------
// dlpl_dp
// Datapath: configuration, current and previous rows, divider, scaling
// multiplier, match test and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dlpl_dp
  import dlpl_pkg::*;
#(
  parameter int unsigned ADDR_WIDTH = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [63:0]          cfg_wdata,
  input  wire logic                 in_unit_start,
  input  wire logic [7:0]           in_func,
  input  wire logic [7:0]           in_ext_func,
  input  wire logic [63:0]          in_operand,
  input  wire logic signed [31:0]   in_line_delta,
  input  wire cmd_t                 cmd,
  output status_t                   st,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [63:0]               out_range_begin,
  output logic [63:0]               out_range_end,
  output logic signed [31:0]        out_line_number,
  output logic [31:0]               out_column_number,
  output logic [31:0]               out_file_index,
  output logic [31:0]               out_discriminator_value,
  output logic [4:0]                out_row_flags
);
  localparam int unsigned AW = ADDR_WIDTH;
  localparam logic [AW-1:0] ADDR_ONES = '1;
  // fresh row flags while the configuration itself is being reset
  localparam logic [4:0] FLAGS_RST =
    5'((1 << FL_INFUNC) | (1 << FL_PROLOG) | (1 << FL_STMT));

  // configuration
  logic [AW-1:0] target_r;
  logic [7:0]    min_insn_r, max_ops_r, line_base_r, line_range_r, opcode_base_r;
  logic          def_stmt_r;

  // item under work
  logic [7:0]  func_r, ext_r;
  logic [63:0] opnd_r;
  logic [31:0] delta_r;

  // rows
  logic [AW-1:0] cur_addr_r, prev_addr_r;
  logic [7:0]    cur_opi_r;
  logic [31:0]   cur_file_r, cur_line_r, cur_col_r, cur_disc_r;
  logic [31:0]   prev_file_r, prev_line_r, prev_col_r, prev_disc_r;
  logic [4:0]    cur_flags_r, prev_flags_r;
  logic          found_r;

  // advance working registers
  logic [63:0]   adv_r, q_r;
  logic [8:0]    r9_r;
  logic [AW-1:0] prod_r;

  logic          out_valid_r;

  logic [7:0]  lr_eff, m_eff, adj;
  logic [4:0]  flags_init;
  logic        is_special;
  kind_t       kind;
  logic [63:0] div_dvd;
  logic [7:0]  div_dvs;
  logic        div_busy;
  logic [63:0] div_quo;
  logic [7:0]  div_rem;
  logic [71:0] prod_full;

  assign lr_eff     = (line_range_r == 8'd0) ? 8'd1 : line_range_r;
  assign m_eff      = (max_ops_r == 8'd0) ? 8'd1 : max_ops_r;
  assign adj        = func_r - opcode_base_r;
  assign is_special = func_r >= opcode_base_r;
  assign flags_init = 5'((1 << FL_INFUNC) | (1 << FL_PROLOG) | (def_stmt_r << FL_STMT));
  assign prod_full  = q_r * min_insn_r;

  always_comb begin
    kind = K_NONE;
    if (is_special) begin
      kind = K_SPECIAL;
    end else begin
      unique case (func_r)
        OP_EXTENDED: begin
          if (ext_r == EXT_END_SEQUENCE) kind = K_ROW;
          else if (ext_r == EXT_SET_ADDRESS || ext_r == EXT_SET_DISCRIM) kind = K_SIMPLE;
        end
        OP_COPY:         kind = K_ROW;
        OP_ADVANCE_PC:   kind = K_ADVPC;
        OP_CONST_ADD_PC: kind = K_CONSTADD;
        OP_ADVANCE_LINE, OP_SET_FILE, OP_SET_COLUMN, OP_NEGATE_STMT, OP_BASIC_BLOCK,
        OP_FIXED_ADV_PC, OP_PROLOGUE_END, OP_EPILOGUE_BEG: kind = K_SIMPLE;
        default:         kind = K_NONE;
      endcase
    end
  end

  always_comb begin
    unique case (cmd.div_sel)
      DSEL_SPECIAL: begin div_dvd = {56'd0, adj};               div_dvs = lr_eff; end
      DSEL_CONST:   begin div_dvd = {56'd0, OPC_MAX - opcode_base_r}; div_dvs = lr_eff; end
      DSEL_ADV:     begin div_dvd = adv_r;                      div_dvs = m_eff;  end
      default:      begin div_dvd = {55'd0, r9_r};              div_dvs = m_eff;  end
    endcase
  end

  dlpl_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .long_mode (cmd.div_sel == DSEL_ADV),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r      <= '0;
      min_insn_r    <= 8'd1;
      max_ops_r     <= 8'd1;
      def_stmt_r    <= 1'b1;
      line_base_r   <= 8'hFB;
      line_range_r  <= 8'd14;
      opcode_base_r <= 8'd13;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_TARGET:      target_r      <= cfg_wdata[AW-1:0];
        CFG_MIN_INSN:    min_insn_r    <= cfg_wdata[7:0];
        CFG_MAX_OPS:     max_ops_r     <= cfg_wdata[7:0];
        CFG_DEF_STMT:    def_stmt_r    <= cfg_wdata[0];
        CFG_LINE_BASE:   line_base_r   <= cfg_wdata[7:0];
        CFG_LINE_RANGE:  line_range_r  <= cfg_wdata[7:0];
        CFG_OPCODE_BASE: opcode_base_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // item latch and working registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r  <= in_func;
      ext_r   <= in_ext_func;
      opnd_r  <= in_operand;
      delta_r <= in_line_delta;
    end
    if (cmd.adv_from_opnd) adv_r <= opnd_r;
    if (cmd.adv_from_quo || cmd.sp_line) adv_r <= div_quo;
    if (cmd.q_from_adv) q_r <= adv_r;
    if (cmd.ad1_capture) begin
      q_r  <= div_quo;
      r9_r <= {1'b0, div_rem} + {1'b0, cur_opi_r};
    end
    if (cmd.ad2_capture) q_r <= q_r + div_quo;
    if (cmd.mul) prod_r <= prod_full[AW-1:0];
  end

  // rows, found flag, result register
  always_ff @(posedge clk) begin
    if (!rst_n || (cmd.accept && in_unit_start)) begin
      cur_addr_r   <= '0;
      cur_opi_r    <= '0;
      cur_file_r   <= 32'd1;
      cur_line_r   <= 32'd1;
      cur_col_r    <= '0;
      cur_disc_r   <= '0;
      cur_flags_r  <= rst_n ? flags_init : FLAGS_RST;
      prev_addr_r  <= ADDR_ONES;
      prev_file_r  <= 32'd1;
      prev_line_r  <= 32'd1;
      prev_col_r   <= '0;
      prev_disc_r  <= '0;
      prev_flags_r <= '0;
      found_r      <= 1'b0;
    end else begin
      if (cmd.apply_simple) begin
        unique case (func_r)
          OP_EXTENDED: begin
            if (ext_r == EXT_SET_ADDRESS) begin
              cur_addr_r <= opnd_r[AW-1:0];
              cur_opi_r  <= '0;
            end else begin
              cur_disc_r <= opnd_r[31:0];
            end
          end
          OP_ADVANCE_LINE: cur_line_r <= cur_line_r + delta_r;
          OP_SET_FILE:     cur_file_r <= opnd_r[31:0];
          OP_SET_COLUMN:   cur_col_r  <= opnd_r[31:0];
          OP_NEGATE_STMT:  cur_flags_r[FL_STMT]   <= ~cur_flags_r[FL_STMT];
          OP_BASIC_BLOCK:  cur_flags_r[FL_BBLOCK] <= 1'b1;
          OP_FIXED_ADV_PC: begin
            cur_addr_r <= cur_addr_r + AW'(opnd_r[15:0]);
            cur_opi_r  <= '0;
          end
          OP_PROLOGUE_END: cur_flags_r[FL_PROLOG] <= 1'b0;
          OP_EPILOGUE_BEG: cur_flags_r[FL_EPILOG] <= 1'b1;
          default: ;
        endcase
      end
      if (cmd.sp_line)
        cur_line_r <= cur_line_r + {24'd0, div_rem} + {{24{line_base_r[7]}}, line_base_r};
      if (cmd.ad2_capture) cur_opi_r <= div_rem;
      if (cmd.add_addr) cur_addr_r <= cur_addr_r + prod_r;
      if (cmd.row_update) begin
        if (!is_special && func_r == OP_EXTENDED) begin
          // end of sequence: fresh current row, previous address invalid
          cur_addr_r  <= '0;
          cur_opi_r   <= '0;
          cur_file_r  <= 32'd1;
          cur_line_r  <= 32'd1;
          cur_col_r   <= '0;
          cur_disc_r  <= '0;
          cur_flags_r <= flags_init;
          prev_addr_r <= ADDR_ONES;
        end else begin
          prev_addr_r  <= cur_addr_r;
          prev_file_r  <= cur_file_r;
          prev_line_r  <= cur_line_r;
          prev_col_r   <= cur_col_r;
          prev_disc_r  <= cur_disc_r;
          prev_flags_r <= cur_flags_r;
          cur_disc_r   <= '0;
          cur_flags_r  <= (cur_flags_r & ~5'((1 << FL_BBLOCK) | (1 << FL_EPILOG)))
                          | 5'(1 << FL_PROLOG);
        end
      end
      if (cmd.load_out) found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_range_begin         <= 64'(prev_addr_r);
      out_range_end           <= 64'(cur_addr_r);
      out_line_number         <= prev_line_r;
      out_column_number       <= prev_col_r;
      out_file_index          <= prev_file_r;
      out_discriminator_value <= prev_disc_r;
      out_row_flags           <= prev_flags_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign st.kind     = kind;
  assign st.found    = found_r;
  assign st.div_busy = div_busy;
  assign st.m_is_one = m_eff == 8'd1;
  assign st.match    = (prev_addr_r <= target_r) && (cur_addr_r > target_r);
  assign st.out_full = out_valid_r;
endmodule
`default_nettype wire

// ----- rtl/dlpl_ctrl.sv -----
// ----------------------------------------------------------------------------
// dlpl_ctrl
// Sequencer: steps the datapath through decode, divisions, scaling and test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "dwarf_line_program_lookup_unit_macros.svh"
module dlpl_ctrl
  import dlpl_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t st,
  output cmd_t         cmd
);
  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SPDIV, S_CADIV, S_ADV, S_AD1, S_AD2S, S_AD2,
    S_MUL, S_ADDA, S_TEST
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    cmd.div_sel = DSEL_SPECIAL;
    state_nxt = state_r;
    in_ready  = state_r == S_IDLE;
    unique case (state_r)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (st.found) begin
          state_nxt = S_IDLE;
        end else begin
          unique case (st.kind)
            K_SIMPLE: begin cmd.apply_simple = 1'b1; state_nxt = S_IDLE; end
            K_ROW:    state_nxt = S_TEST;
            K_SPECIAL: begin
              cmd.div_start = 1'b1; cmd.div_sel = DSEL_SPECIAL; state_nxt = S_SPDIV;
            end
            K_CONSTADD: begin
              cmd.div_start = 1'b1; cmd.div_sel = DSEL_CONST; state_nxt = S_CADIV;
            end
            K_ADVPC:  begin cmd.adv_from_opnd = 1'b1; state_nxt = S_ADV; end
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_SPDIV: if (!st.div_busy) begin cmd.sp_line = 1'b1; state_nxt = S_ADV; end
      S_CADIV: if (!st.div_busy) begin cmd.adv_from_quo = 1'b1; state_nxt = S_ADV; end
      S_ADV: begin
        if (st.m_is_one) begin
          cmd.q_from_adv = 1'b1;
          state_nxt = S_MUL;
        end else begin
          cmd.div_start = 1'b1; cmd.div_sel = DSEL_ADV; state_nxt = S_AD1;
        end
      end
      S_AD1:  if (!st.div_busy) begin cmd.ad1_capture = 1'b1; state_nxt = S_AD2S; end
      S_AD2S: begin cmd.div_start = 1'b1; cmd.div_sel = DSEL_R9; state_nxt = S_AD2; end
      S_AD2:  if (!st.div_busy) begin
        cmd.div_sel = DSEL_R9; cmd.ad2_capture = 1'b1; state_nxt = S_MUL;
      end
      S_MUL:  begin cmd.mul = 1'b1; state_nxt = S_ADDA; end
      S_ADDA: begin
        cmd.add_addr = 1'b1;
        state_nxt = (st.kind == K_SPECIAL) ? S_TEST : S_IDLE;
      end
      S_TEST: begin
        if (!st.match) begin
          cmd.row_update = 1'b1; state_nxt = S_IDLE;
        end else if (!st.out_full) begin
          cmd.load_out = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  `DLPL_ASSERT_NXT(a_accept_decodes, cmd.accept, state_r == S_DECODE, "accept not followed by decode")
  `DLPL_ASSERT_IMP(a_load_free, cmd.load_out, !st.out_full, "result loaded over pending one")
  `DLPL_ASSERT_IMP(a_div_idle, cmd.div_start, !st.div_busy, "divider restarted while busy")
  `DLPL_ASSERT_NXT(a_div_runs, cmd.div_start, st.div_busy, "divider did not start")
endmodule
`default_nettype wire
